@@ hw/rtl/gpm_pkg.sv @@
package gpm_pkg;

    localparam int REG_W    = 7;
    localparam int OP_W     = 2;
    localparam int COORD_W  = 6;
    localparam int DIGIT_W  = 4;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [OP_W-1:0] OP_WR_GRID    = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_PATTERN = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH     = 2'd2;

    localparam logic [1:0] REG_GRID_ROWS    = 2'd0;
    localparam logic [1:0] REG_GRID_COLS    = 2'd1;
    localparam logic [1:0] REG_PATTERN_ROWS = 2'd2;
    localparam logic [1:0] REG_PATTERN_COLS = 2'd3;

    localparam logic [REG_W-1:0] DIM_RESET = 7'd1;

endpackage

@@ hw/rtl/gpm_in_if.sv @@
interface gpm_in_if;
    logic                           valid;
    logic                           ready;
    logic [gpm_pkg::OP_W-1:0]       opcode;
    logic [gpm_pkg::COORD_W-1:0]    cell_row;
    logic [gpm_pkg::COORD_W-1:0]    cell_col;
    logic [gpm_pkg::DIGIT_W-1:0]    digit;

    modport source (output valid, output opcode, output cell_row, output cell_col,
                    output digit, input ready);
    modport sink   (input valid, input opcode, input cell_row, input cell_col,
                    input digit, output ready);
endinterface

@@ hw/rtl/gpm_out_if.sv @@
interface gpm_out_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

@@ hw/rtl/gpm_ram.sv @@
module gpm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/grid_pattern_match_core.sv @@
// cell writes: one beat per cycle while idle (ready is low during a search), ready again in the next cycle
// search: sizes are captured on the search beat, checked in SETUP, then each compared cell
//   takes a read (READ) and a compare (CMP) on the grid and pattern read ports, which are
//   read together; FINISH then posts the result
// a result still held at the output keeps the sequencer in FINISH until it is taken
// reset: synchronous active low, size registers go to 1, stores are not cleared
module grid_pattern_match_core #(
    parameter int MAX_ROWS = gpm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gpm_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    gpm_in_if.sink                      i_in,
    gpm_out_if.source                   o_out,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [gpm_pkg::APB_AW-1:0]  i_paddr,
    input  logic [gpm_pkg::APB_DW-1:0]  i_pwdata,
    output logic [gpm_pkg::APB_DW-1:0]  o_prdata,
    output logic                        o_pready
);
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW     = gpm_pkg::REG_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_READ   = 5'b00100,
        ST_CMP    = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [RW-1:0] r_grid_rows, r_grid_cols, r_pat_rows, r_pat_cols;
    logic [RW-1:0] r_gr, r_gc, r_pr, r_pc;
    logic [RW-1:0] n_gr, n_gc, n_pr, n_pc;
    logic [RW-1:0] r_r0, r_c0, r_i, r_j;
    logic [RW-1:0] n_r0, n_c0, n_i, n_j;
    logic          r_hit, n_hit;
    logic          r_out_valid, n_out_valid;
    logic          r_found, n_found;

    logic                      in_acc, wr_ok, cfg_wr;
    logic [ADDR_W-1:0]         wr_addr, grid_raddr, pat_raddr;
    logic [gpm_pkg::DIGIT_W-1:0] grid_rdata, pat_rdata;
    logic [RW:0]               g_row, g_col, next_c_end, next_r_end;

    // ---------------- configuration port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= gpm_pkg::DIM_RESET;
            r_grid_cols <= gpm_pkg::DIM_RESET;
            r_pat_rows  <= gpm_pkg::DIM_RESET;
            r_pat_cols  <= gpm_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            case (i_paddr[3:2])
                gpm_pkg::REG_GRID_ROWS:    r_grid_rows <= i_pwdata[RW-1:0];
                gpm_pkg::REG_GRID_COLS:    r_grid_cols <= i_pwdata[RW-1:0];
                gpm_pkg::REG_PATTERN_ROWS: r_pat_rows  <= i_pwdata[RW-1:0];
                gpm_pkg::REG_PATTERN_COLS: r_pat_cols  <= i_pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            gpm_pkg::REG_GRID_ROWS:    o_prdata = gpm_pkg::APB_DW'(r_grid_rows);
            gpm_pkg::REG_GRID_COLS:    o_prdata = gpm_pkg::APB_DW'(r_grid_cols);
            gpm_pkg::REG_PATTERN_ROWS: o_prdata = gpm_pkg::APB_DW'(r_pat_rows);
            gpm_pkg::REG_PATTERN_COLS: o_prdata = gpm_pkg::APB_DW'(r_pat_cols);
            default:                   o_prdata = '0;
        endcase
    end

    // ---------------- cell stores
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign wr_ok      = (32'(i_in.cell_row) < MAX_ROWS) && (32'(i_in.cell_col) < MAX_COLS);
    assign wr_addr    = ADDR_W'(32'(i_in.cell_row) * MAX_COLS + 32'(i_in.cell_col));

    assign g_row      = {1'b0, r_r0} + {1'b0, r_i};
    assign g_col      = {1'b0, r_c0} + {1'b0, r_j};
    assign grid_raddr = ADDR_W'(32'(g_row) * MAX_COLS + 32'(g_col));
    assign pat_raddr  = ADDR_W'(32'(r_i) * MAX_COLS + 32'(r_j));

    gpm_ram #(.WIDTH(gpm_pkg::DIGIT_W), .DEPTH(CELLS)) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && wr_ok && (i_in.opcode == gpm_pkg::OP_WR_GRID)),
        .i_waddr (wr_addr),
        .i_wdata (i_in.digit),
        .i_re    (r_state == ST_READ),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    gpm_ram #(.WIDTH(gpm_pkg::DIGIT_W), .DEPTH(CELLS)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && wr_ok && (i_in.opcode == gpm_pkg::OP_WR_PATTERN)),
        .i_waddr (wr_addr),
        .i_wdata (i_in.digit),
        .i_re    (r_state == ST_READ),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    // ---------------- search sequencer
    // end of the next placement along a row, and of the next placement row
    assign next_c_end = {1'b0, r_c0} + {1'b0, r_pc} + (RW+1)'(1);
    assign next_r_end = {1'b0, r_r0} + {1'b0, r_pr} + (RW+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_gr        = r_gr;
        n_gc        = r_gc;
        n_pr        = r_pr;
        n_pc        = r_pc;
        n_r0        = r_r0;
        n_c0        = r_c0;
        n_i         = r_i;
        n_j         = r_j;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_found     = r_found;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.opcode == gpm_pkg::OP_SEARCH) begin
                    // sizes above the store saturate
                    n_gr    = (32'(r_grid_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : r_grid_rows;
                    n_gc    = (32'(r_grid_cols) > MAX_COLS) ? RW'(MAX_COLS) : r_grid_cols;
                    n_pr    = (32'(r_pat_rows)  > MAX_ROWS) ? RW'(MAX_ROWS) : r_pat_rows;
                    n_pc    = (32'(r_pat_cols)  > MAX_COLS) ? RW'(MAX_COLS) : r_pat_cols;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_r0 = '0;
                n_c0 = '0;
                n_i  = '0;
                n_j  = '0;
                if (r_gr == '0 || r_gc == '0 || r_pr == '0 || r_pc == '0 ||
                    r_pr > r_gr || r_pc > r_gc) begin
                    n_hit   = 1'b0;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_READ;
                if (grid_rdata != pat_rdata) begin
                    n_i = '0;
                    n_j = '0;
                    if (next_c_end <= {1'b0, r_gc}) begin
                        n_c0 = r_c0 + RW'(1);
                    end else begin
                        n_c0 = '0;
                        if (next_r_end <= {1'b0, r_gr}) begin
                            n_r0 = r_r0 + RW'(1);
                        end else begin
                            n_hit   = 1'b0;
                            n_state = ST_FINISH;
                        end
                    end
                end else if (r_j + RW'(1) != r_pc) begin
                    n_j = r_j + RW'(1);
                end else begin
                    n_j = '0;
                    if (r_i + RW'(1) != r_pr) begin
                        n_i = r_i + RW'(1);
                    end else begin
                        n_hit   = 1'b1;
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                // wait here while an older result is still held
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_gr    <= n_gr;
        r_gc    <= n_gc;
        r_pr    <= n_pr;
        r_pc    <= n_pc;
        r_r0    <= n_r0;
        r_c0    <= n_c0;
        r_i     <= n_i;
        r_j     <= n_j;
        r_hit   <= n_hit;
        r_found <= n_found;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.found = r_found;

    // ---------------- checks
    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.opcode == gpm_pkg::OP_SEARCH) |=> (r_state == ST_SETUP))
        else $error("search beat did not start the sequencer");

    a_walk_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |->
            (r_i < r_pr && r_j < r_pc &&
             ({1'b0, r_r0} + {1'b0, r_pr} <= {1'b0, r_gr}) &&
             ({1'b0, r_c0} + {1'b0, r_pc} <= {1'b0, r_gc})))
        else $error("placement walk left the grid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_valid && !o_out.ready) |=>
            (r_state == ST_FINISH && r_out_valid))
        else $error("pending result overwritten");
endmodule
